/* src/cse_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the cardinal spline evaluator.
// No dependencies; used by cse_div_stage and cardinal_spline_eval.
package cse_pkg;

	// Register map: the register index is paddr[2].
	localparam logic IDX_TENSION_GAIN = 1'b0;
	localparam logic [15:0] TENSION_RESET = 16'd4096;

	// Restoring divider shape: 36 quotient bits, 16-bit divisor, 4 bits per stage.
	localparam int DIVW       = 36;
	localparam int DENW       = 16;
	localparam int DIV_STEPS  = 4;
	localparam int DIV_STAGES = DIVW / DIV_STEPS;

	// Tangent numerator width and the Q12 scale of the tension.
	localparam int NUMW      = 48;
	localparam int TAN_SHIFT = 12;

	// Divider lanes: two tangents and the local parameter.
	localparam int LANE_T1   = 0;
	localparam int LANE_T2   = 1;
	localparam int LANE_S    = 2;
	localparam int NUM_LANES = 3;

	// Pipeline stage positions.
	localparam int ST_S1      = 0;
	localparam int ST_S2      = 1;
	localparam int ST_S3      = 2;
	localparam int DIV_FIRST  = 3;
	localparam int ST_SIGN    = DIV_FIRST + DIV_STAGES;
	localparam int ST_SQ      = ST_SIGN + 1;
	localparam int ST_CUBE    = ST_SIGN + 2;
	localparam int ST_BASIS   = ST_SIGN + 3;
	localparam int ST_PROD    = ST_SIGN + 4;
	localparam int ST_PAIR    = ST_SIGN + 5;
	localparam int ST_OUT     = ST_SIGN + 6;
	localparam int NUM_STAGES = ST_OUT + 1;

	localparam logic [16:0] S_ONE = 17'd65536;

	typedef struct packed {
		logic [DENW-1:0] rem;
		logic [DIVW-1:0] work;
		logic [DENW-1:0] den;
	} div_lane_t;

	typedef struct packed {
		logic        seg_zero;
		logic        sneg;
		logic        tan1_neg;
		logic        tan1_zero;
		logic        tan2_neg;
		logic        tan2_zero;
		logic [15:0] vs;
		logic [15:0] ve;
	} side_t;

	function automatic logic [15:0] mag17(input logic signed [16:0] x);
		logic signed [16:0] n;
		n = -x;
		return x[16] ? n[15:0] : x[15:0];
	endfunction

endpackage

/* src/cse_div_stage.sv */
`timescale 1ns / 1ps
// One pipeline stage of a restoring divider lane: DIV_STEPS quotient bits per stage.
// Depends on cse_pkg for the lane type and divider widths.
module cse_div_stage (
	input  logic                 clk,
	input  logic                 en,
	input  cse_pkg::div_lane_t   lane_in,
	output cse_pkg::div_lane_t   lane_s1
);

	cse_pkg::div_lane_t nxt;

	always_comb begin
		logic [cse_pkg::DENW:0]   shifted;
		logic [cse_pkg::DENW-1:0] rem;
		logic [cse_pkg::DIVW-1:0] work;
		logic                     qbit;
		rem = lane_in.rem;
		work = lane_in.work;
		for (int i = 0; i < cse_pkg::DIV_STEPS; i++) begin
			shifted = {rem, work[cse_pkg::DIVW-1]};
			if (shifted >= {1'b0, lane_in.den}) begin
				rem = cse_pkg::DENW'(shifted - {1'b0, lane_in.den});
				qbit = 1'b1;
			end else begin
				rem = shifted[cse_pkg::DENW-1:0];
				qbit = 1'b0;
			end
			work = {work[cse_pkg::DIVW-2:0], qbit};
		end
		nxt.rem = rem;
		nxt.work = work;
		nxt.den = lane_in.den;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lane_s1 <= nxt;
		end
	end

endmodule

/* src/cardinal_spline_eval.sv */
`timescale 1ns / 1ps
// Top level of the cardinal spline evaluator: APB register, input conditioning,
// pipelined dividers (cse_div_stage) and the Hermite blend. Depends on cse_pkg.
//
// Channel  | Handshake                      | Payload
// sample   | sample_valid / sample_stall    | sample_time, time_*, value_*
// result   | result_valid / result_stall    | blended_value, saturated
// config   | psel, penable, pwrite, pready  | paddr, pwdata, prdata
//
// One transaction is accepted every cycle while sample_stall is low; it passes 19 register
// stages on its way to blended_value and saturated.
// The three 36-bit restoring dividers run side by side at 4 quotient bits per stage.
// Every stage has its own valid bit and moves when the stage ahead is empty or moving,
// so a result stall holds the full stages and bubbles still close up.
// arst_n clears all valid bits and sets tension_gain to 4096 (tension one).
module cardinal_spline_eval (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               sample_valid,
	output logic               sample_stall,
	input  logic [15:0]        sample_time,
	input  logic [15:0]        time_before,
	input  logic [15:0]        time_start,
	input  logic [15:0]        time_end,
	input  logic [15:0]        time_after,
	input  logic signed [15:0] value_before,
	input  logic signed [15:0] value_start,
	input  logic signed [15:0] value_end,
	input  logic signed [15:0] value_after,
	output logic               result_valid,
	input  logic               result_stall,
	output logic signed [15:0] blended_value,
	output logic               saturated
);

	localparam int NS = cse_pkg::NUM_STAGES;

	logic [15:0]   tension_gain_q;
	logic [NS-1:0] vld_s;
	logic [NS-1:0] ld;

	// Configuration port
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tension_gain_q <= cse_pkg::TENSION_RESET;
		end else if (psel && penable && pwrite && pready
				&& paddr[2] == cse_pkg::IDX_TENSION_GAIN) begin
			tension_gain_q <= pwdata[15:0];
		end
	end

	always_comb begin
		if (paddr[2] == cse_pkg::IDX_TENSION_GAIN) begin
			prdata = {16'd0, tension_gain_q};
		end else begin
			prdata = 32'd0;
		end
	end

	// Pipeline flow control
	always_comb begin
		ld[NS-1] = !vld_s[NS-1] || !result_stall;
		for (int k = NS - 2; k >= 0; k--) begin
			ld[k] = !vld_s[k] || ld[k+1];
		end
	end

	assign sample_stall = !ld[0];
	assign result_valid = vld_s[NS-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (ld[0]) begin
				vld_s[0] <= sample_valid;
			end
			for (int k = 1; k < NS; k++) begin
				if (ld[k]) begin
					vld_s[k] <= vld_s[k-1];
				end
			end
		end
	end

	// Stage 1: differences, magnitudes and signs
	logic signed [16:0] seg_d, dv1_d, dv2_d, span1_d, span2_d, dt_d;
	cse_pkg::side_t     side_d;

	always_comb begin
		seg_d   = $signed({1'b0, time_end}) - $signed({1'b0, time_start});
		span1_d = $signed({1'b0, time_end}) - $signed({1'b0, time_before});
		span2_d = $signed({1'b0, time_after}) - $signed({1'b0, time_start});
		dt_d    = $signed({1'b0, sample_time}) - $signed({1'b0, time_start});
		dv1_d   = $signed({value_end[15], value_end}) - $signed({value_before[15], value_before});
		dv2_d   = $signed({value_after[15], value_after}) - $signed({value_start[15], value_start});
		side_d.seg_zero  = (seg_d == 17'sd0);
		side_d.sneg      = dt_d[16] ^ seg_d[16];
		side_d.tan1_neg  = seg_d[16] ^ dv1_d[16] ^ span1_d[16];
		side_d.tan1_zero = (span1_d == 17'sd0);
		side_d.tan2_neg  = seg_d[16] ^ dv2_d[16] ^ span2_d[16];
		side_d.tan2_zero = (span2_d == 17'sd0);
		side_d.vs        = value_start;
		side_d.ve        = value_end;
	end

	cse_pkg::side_t side_s1, side_s2, side_s3;
	logic [15:0] seg_mag_s1, dv1_mag_s1, dv2_mag_s1, span1_mag_s1, span2_mag_s1, dt_mag_s1;
	logic [15:0] seg_mag_s2, dv1_mag_s2, dv2_mag_s2, span1_mag_s2, span2_mag_s2, dt_mag_s2;
	logic [31:0] segt_s2;
	cse_pkg::div_lane_t lane_s3 [cse_pkg::NUM_LANES];

	always_ff @(posedge clk) begin
		if (ld[cse_pkg::ST_S1]) begin
			side_s1      <= side_d;
			seg_mag_s1   <= cse_pkg::mag17(seg_d);
			dv1_mag_s1   <= cse_pkg::mag17(dv1_d);
			dv2_mag_s1   <= cse_pkg::mag17(dv2_d);
			span1_mag_s1 <= cse_pkg::mag17(span1_d);
			span2_mag_s1 <= cse_pkg::mag17(span2_d);
			dt_mag_s1    <= cse_pkg::mag17(dt_d);
		end
	end

	// Stage 2: segment length times tension
	always_ff @(posedge clk) begin
		if (ld[cse_pkg::ST_S2]) begin
			side_s2      <= side_s1;
			segt_s2      <= 32'(seg_mag_s1) * 32'(tension_gain_q);
			seg_mag_s2   <= seg_mag_s1;
			dv1_mag_s2   <= dv1_mag_s1;
			dv2_mag_s2   <= dv2_mag_s1;
			span1_mag_s2 <= span1_mag_s1;
			span2_mag_s2 <= span2_mag_s1;
			dt_mag_s2    <= dt_mag_s1;
		end
	end

	// Stage 3: tangent numerators, loaded into the divider lanes
	logic [cse_pkg::NUMW-1:0] num1_d, num2_d;

	assign num1_d = cse_pkg::NUMW'(segt_s2) * cse_pkg::NUMW'(dv1_mag_s2);
	assign num2_d = cse_pkg::NUMW'(segt_s2) * cse_pkg::NUMW'(dv2_mag_s2);

	always_ff @(posedge clk) begin
		if (ld[cse_pkg::ST_S3]) begin
			side_s3 <= side_s2;
			lane_s3[cse_pkg::LANE_T1].rem  <= '0;
			lane_s3[cse_pkg::LANE_T1].work <=
				num1_d[cse_pkg::NUMW-1:cse_pkg::TAN_SHIFT];
			lane_s3[cse_pkg::LANE_T1].den  <= span1_mag_s2;
			lane_s3[cse_pkg::LANE_T2].rem  <= '0;
			lane_s3[cse_pkg::LANE_T2].work <=
				num2_d[cse_pkg::NUMW-1:cse_pkg::TAN_SHIFT];
			lane_s3[cse_pkg::LANE_T2].den  <= span2_mag_s2;
			// Local parameter: |t - ts| in Q16 over the segment length.
			lane_s3[cse_pkg::LANE_S].rem   <= '0;
			lane_s3[cse_pkg::LANE_S].work  <= {4'd0, dt_mag_s2, 16'd0};
			lane_s3[cse_pkg::LANE_S].den   <= seg_mag_s2;
		end
	end

	// Divider stages
	cse_pkg::div_lane_t lane_sdiv [cse_pkg::DIV_STAGES][cse_pkg::NUM_LANES];
	cse_pkg::side_t     side_sdiv [cse_pkg::DIV_STAGES];

	for (genvar k = 0; k < cse_pkg::DIV_STAGES; k++) begin : g_div
		for (genvar l = 0; l < cse_pkg::NUM_LANES; l++) begin : g_lane
			cse_pkg::div_lane_t lane_in;
			if (k == 0) begin : g_first
				assign lane_in = lane_s3[l];
			end else begin : g_next
				assign lane_in = lane_sdiv[k-1][l];
			end
			cse_div_stage u_stage (
				.clk     (clk),
				.en      (ld[cse_pkg::DIV_FIRST + k]),
				.lane_in (lane_in),
				.lane_s1 (lane_sdiv[k][l])
			);
		end
	end

	always_ff @(posedge clk) begin
		if (ld[cse_pkg::DIV_FIRST]) begin
			side_sdiv[0] <= side_s3;
		end
		for (int k = 1; k < cse_pkg::DIV_STAGES; k++) begin
			if (ld[cse_pkg::DIV_FIRST + k]) begin
				side_sdiv[k] <= side_sdiv[k-1];
			end
		end
	end

	// Sign and clamp of the quotients
	localparam int LAST = cse_pkg::DIV_STAGES - 1;

	logic [cse_pkg::DIVW-1:0] q1_d, q2_d, qs_d;
	logic signed [36:0]       d1_d, d2_d;
	logic [16:0]              s_d;

	always_comb begin
		q1_d = lane_sdiv[LAST][cse_pkg::LANE_T1].work;
		q2_d = lane_sdiv[LAST][cse_pkg::LANE_T2].work;
		qs_d = lane_sdiv[LAST][cse_pkg::LANE_S].work;
		if (side_sdiv[LAST].tan1_zero) begin
			d1_d = '0;
		end else if (side_sdiv[LAST].tan1_neg) begin
			d1_d = -$signed({1'b0, q1_d});
		end else begin
			d1_d = $signed({1'b0, q1_d});
		end
		if (side_sdiv[LAST].tan2_zero) begin
			d2_d = '0;
		end else if (side_sdiv[LAST].tan2_neg) begin
			d2_d = -$signed({1'b0, q2_d});
		end else begin
			d2_d = $signed({1'b0, q2_d});
		end
		if (side_sdiv[LAST].sneg) begin
			s_d = '0;
		end else if (qs_d > cse_pkg::DIVW'(cse_pkg::S_ONE)) begin
			s_d = cse_pkg::S_ONE;
		end else begin
			s_d = qs_d[16:0];
		end
	end

	cse_pkg::side_t     side_s13, side_s14, side_s15, side_s16, side_s17, side_s18;
	logic signed [36:0] d1_s13, d2_s13, d1_s14, d2_s14, d1_s15, d2_s15, d1_s16, d2_s16;
	logic [16:0]        s_s13, s_s14, s_s15, s2_s14, s2_s15, s3_s15;

	always_ff @(posedge clk) begin
		if (ld[cse_pkg::ST_SIGN]) begin
			side_s13 <= side_sdiv[LAST];
			d1_s13   <= d1_d;
			d2_s13   <= d2_d;
			s_s13    <= s_d;
		end
	end

	// Powers of s
	logic [33:0] sq_d, cube_d;

	assign sq_d   = 34'(s_s13) * 34'(s_s13);
	assign cube_d = 34'(s2_s14) * 34'(s_s14);

	always_ff @(posedge clk) begin
		if (ld[cse_pkg::ST_SQ]) begin
			side_s14 <= side_s13;
			d1_s14   <= d1_s13;
			d2_s14   <= d2_s13;
			s_s14    <= s_s13;
			s2_s14   <= sq_d[32:16];
		end
		if (ld[cse_pkg::ST_CUBE]) begin
			side_s15 <= side_s14;
			d1_s15   <= d1_s14;
			d2_s15   <= d2_s14;
			s_s15    <= s_s14;
			s2_s15   <= s2_s14;
			s3_s15   <= cube_d[32:16];
		end
	end

	// Hermite basis in Q16
	logic signed [18:0] s_e, s2_e, s3_e;
	logic signed [18:0] h00_s16, h10_s16, h01_s16, h11_s16;

	assign s_e  = $signed({2'b00, s_s15});
	assign s2_e = $signed({2'b00, s2_s15});
	assign s3_e = $signed({2'b00, s3_s15});

	always_ff @(posedge clk) begin
		if (ld[cse_pkg::ST_BASIS]) begin
			side_s16 <= side_s15;
			d1_s16   <= d1_s15;
			d2_s16   <= d2_s15;
			h00_s16  <= (s3_e <<< 1) - (s2_e + (s2_e <<< 1)) + 19'sd65536;
			h10_s16  <= s3_e - (s2_e <<< 1) + s_e;
			h01_s16  <= (s2_e + (s2_e <<< 1)) - (s3_e <<< 1);
			h11_s16  <= s3_e - s2_e;
		end
	end

	// Weighted terms
	logic signed [34:0] p00_d, p01_d, p00_s17, p01_s17;
	logic signed [55:0] p10_d, p11_d, p10_s17, p11_s17;

	assign p00_d = h00_s16 * $signed(side_s16.vs);
	assign p01_d = h01_s16 * $signed(side_s16.ve);
	assign p10_d = h10_s16 * d1_s16;
	assign p11_d = h11_s16 * d2_s16;

	logic signed [35:0] sum_v_s18;
	logic signed [56:0] sum_d_s18;

	always_ff @(posedge clk) begin
		if (ld[cse_pkg::ST_PROD]) begin
			side_s17 <= side_s16;
			p00_s17  <= p00_d;
			p01_s17  <= p01_d;
			p10_s17  <= p10_d;
			p11_s17  <= p11_d;
		end
		if (ld[cse_pkg::ST_PAIR]) begin
			side_s18  <= side_s17;
			sum_v_s18 <= 36'(p00_s17) + 36'(p01_s17);
			sum_d_s18 <= 57'(p10_s17) + 57'(p11_s17);
		end
	end

	// Round half up to Q4.12 and saturate
	logic signed [57:0] acc_d, rnd_d;
	logic signed [41:0] r_d;
	logic signed [15:0] val_d;
	logic               sat_d;

	always_comb begin
		acc_d = 58'(sum_v_s18) + 58'(sum_d_s18);
		rnd_d = acc_d + 58'sd32768;
		r_d   = rnd_d[57:16];
		if (side_s18.seg_zero) begin
			// An empty segment returns the start value unchanged.
			val_d = $signed(side_s18.vs);
			sat_d = 1'b0;
		end else if (r_d > 42'sd32767) begin
			val_d = 16'sh7FFF;
			sat_d = 1'b1;
		end else if (r_d < -42'sd32768) begin
			val_d = 16'sh8000;
			sat_d = 1'b1;
		end else begin
			val_d = r_d[15:0];
			sat_d = 1'b0;
		end
	end

	logic signed [15:0] blended_value_s19;
	logic               saturated_s19;

	always_ff @(posedge clk) begin
		if (ld[cse_pkg::ST_OUT]) begin
			blended_value_s19 <= val_d;
			saturated_s19     <= sat_d;
		end
	end

	assign blended_value = blended_value_s19;
	assign saturated     = saturated_s19;

`ifndef SYNTH
	a_sat_at_rail: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && saturated |-> (blended_value == 16'sh7FFF || blended_value == 16'sh8000))
		else $error("saturated flag set on a value that is not a rail");

	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && !sample_stall |=> vld_s[0])
		else $error("accepted transaction did not enter the first stage");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		sample_stall |-> (&vld_s) && result_stall)
		else $error("input stalled while the pipeline has room");

	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[NS-2] && !ld[NS-1] |=> vld_s[NS-2] && vld_s[NS-1])
		else $error("held transaction lost in front of the output stage");
`endif

endmodule
